// ----- hdl/assert_macros.svh -----
// assertion helpers for the editor
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// ----- hdl/kted_pkg.sv -----
package kted_pkg;
    localparam int DEF_BUF_DEPTH = 4096;
    localparam int IDX_W = 12;

    localparam logic [2:0] REQ_KEY   = 3'd0;
    localparam logic [2:0] REQ_LOAD  = 3'd1;
    localparam logic [2:0] REQ_SAVED = 3'd2;
    localparam logic [2:0] REQ_READ  = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;

    localparam logic [7:0] K_ESC   = 8'h1b;
    localparam logic [7:0] K_SAVE  = 8'h0f;
    localparam logic [7:0] K_EXIT  = 8'h18;
    localparam logic [7:0] K_DEL   = 8'h7f;
    localparam logic [7:0] K_BS    = 8'h08;
    localparam logic [7:0] K_SPACE = 8'h20;
    localparam logic [7:0] K_CR    = 8'h0d;
    localparam logic [7:0] K_LF    = 8'h0a;
    localparam logic [7:0] K_LBR   = 8'h5b;
    localparam logic [7:0] K_UP    = 8'h41;
    localparam logic [7:0] K_DOWN  = 8'h42;
    localparam logic [7:0] K_RIGHT = 8'h43;
    localparam logic [7:0] K_LEFT  = 8'h44;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_SAVE = 2'd1;
    localparam logic [1:0] CMD_EXIT = 2'd2;

    // escape sequence progress in the decoder
    typedef enum logic [1:0] {
        ESC_NONE, ESC_SEEN, ESC_CSI
    } esc_state_t;

    // operations passed from the decoder to the executor
    typedef enum logic [3:0] {
        OP_NONE, OP_INSERT, OP_DELETE, OP_LOAD, OP_SAVED, OP_READ, OP_CLEAR,
        OP_LEFT, OP_RIGHT, OP_UP, OP_DOWN
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic [IDX_W-1:0] index;
        logic [1:0] cmd;
    } cmd_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SHIFT_UP, ST_SHIFT_DN, ST_READ_WAIT, ST_SCAN_BACK, ST_SCAN_BACK2,
        ST_SCAN_FWD, ST_SCAN_FWD2, ST_DONE
    } exec_state_t;
endpackage

// ----- hdl/kted_decode.sv -----
module kted_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [2:0]            req_type,
    input  logic [7:0]            key_byte,
    input  logic [11:0]           read_index,
    output kted_pkg::cmd_item_t   item
);
    import kted_pkg::*;

    logic       after_cr_reg, after_cr_next;
    esc_state_t esc_reg, esc_next;

    // classify one request and track escape / cr state
    always_comb
    begin
        after_cr_next = after_cr_reg;
        esc_next      = esc_reg;
        item.op       = OP_NONE;
        item.data     = key_byte;
        item.index    = read_index;
        item.cmd      = CMD_NONE;
        case (req_type)
            REQ_KEY:
            begin
                if (esc_reg == ESC_SEEN)
                begin
                    esc_next = (key_byte == K_LBR) ? ESC_CSI : ESC_NONE;
                end
                else if (esc_reg == ESC_CSI)
                begin
                    esc_next = ESC_NONE;
                    case (key_byte)
                        K_UP:    item.op = OP_UP;
                        K_DOWN:  item.op = OP_DOWN;
                        K_RIGHT: item.op = OP_RIGHT;
                        K_LEFT:  item.op = OP_LEFT;
                        default: item.op = OP_NONE;
                    endcase
                end
                else if (after_cr_reg && key_byte == K_LF)
                begin
                    after_cr_next = 1'b0;
                end
                else
                begin
                    after_cr_next = 1'b0;
                    if (key_byte == K_ESC)
                        esc_next = ESC_SEEN;
                    else if (key_byte == K_SAVE)
                        item.cmd = CMD_SAVE;
                    else if (key_byte == K_EXIT)
                        item.cmd = CMD_EXIT;
                    else if (key_byte == K_CR)
                    begin
                        item.op       = OP_INSERT;
                        item.data     = K_LF;
                        after_cr_next = 1'b1;
                    end
                    else if (key_byte == K_DEL || key_byte == K_BS)
                        item.op = OP_DELETE;
                    else if (key_byte >= K_SPACE && key_byte < K_DEL)
                        item.op = OP_INSERT;
                end
            end
            REQ_LOAD:  item.op = OP_LOAD;
            REQ_SAVED: item.op = OP_SAVED;
            REQ_READ:  item.op = OP_READ;
            REQ_CLEAR:
            begin
                item.op       = OP_CLEAR;
                after_cr_next = 1'b0;
                esc_next      = ESC_NONE;
            end
            default: item.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_cr_reg <= 1'b0;
            esc_reg      <= ESC_NONE;
        end
        else if (in_valid)
        begin
            after_cr_reg <= after_cr_next;
            esc_reg      <= esc_next;
        end
    end
endmodule

// ----- hdl/kted_fifo.sv -----
module kted_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  kted_pkg::cmd_item_t wr_item,
    input  logic                rd_en,
    output kted_pkg::cmd_item_t rd_item,
    output logic                empty,
    output logic                full
);
    import kted_pkg::*;

    cmd_item_t  slot_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg, rp_reg;

    assign empty   = (cnt_reg == 2'd0);
    assign full    = (cnt_reg == 2'd2);
    assign rd_item = slot_reg[rp_reg];

    // two-entry queue between decoder and executor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= ~wp_reg;
            if (rd_en)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wp_reg] <= wr_item;
    end
endmodule

// ----- hdl/kted_exec.sv -----
`include "assert_macros.svh"
module kted_exec #(
    parameter int BUF_DEPTH = kted_pkg::DEF_BUF_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  kted_pkg::cmd_item_t q_item,
    output logic                q_pop,
    output logic                idle,
    output logic                done,
    output logic [11:0]         cursor_pos,
    output logic [11:0]         text_length,
    output logic                modified,
    output logic [1:0]          command,
    output logic [7:0]          read_data
);
    import kted_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);
    localparam logic [AW:0] FULL_LEN = (AW+1)'(BUF_DEPTH - 1);

    logic [7:0] mem [BUF_DEPTH];

    exec_state_t st_reg, st_next;
    cmd_item_t   it_reg;
    logic [AW:0] len_reg, len_next;
    logic [AW:0] cur_reg, cur_next;
    logic        dirty_reg, dirty_next;
    logic [AW:0] ptr_reg, ptr_next;
    logic [AW:0] col_reg, col_next;
    logic [AW:0] ls_reg, ls_next;
    logic        done_reg;
    logic [1:0]  cmd_reg;
    logic [7:0]  rd_reg, rd_next;

    // memory port control
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata_reg;
    logic [7:0]    hold_reg, hold_next;

    logic [AW:0] idx_ext;
    assign idx_ext = (AW+1)'(q_item.index);

    assign q_pop = (st_reg == ST_IDLE) && !q_empty;
    assign idle  = (st_reg == ST_IDLE) && q_empty && !done_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    function automatic logic [AW:0] min_w(input logic [AW:0] a, input logic [AW:0] b);
        min_w = (a < b) ? a : b;
    endfunction

    // next state
    always_comb
    begin
        st_next    = st_reg;
        len_next   = len_reg;
        cur_next   = cur_reg;
        dirty_next = dirty_reg;
        ptr_next   = ptr_reg;
        col_next   = col_reg;
        ls_next    = ls_reg;
        rd_next    = rd_reg;
        hold_next  = hold_reg;
        we         = 1'b0;
        waddr      = ptr_reg[AW-1:0];
        wdata      = hold_reg;
        raddr      = ptr_reg[AW-1:0];
        case (st_reg)
            ST_IDLE:
            begin
                rd_next = 8'd0;
                if (!q_empty)
                begin
                    st_next = ST_DONE;
                    case (q_item.op)
                        OP_INSERT:
                        begin
                            if (len_reg < FULL_LEN)
                            begin
                                // carry the new byte up the tail, one byte a cycle
                                ptr_next   = cur_reg;
                                hold_next  = q_item.data;
                                raddr      = cur_reg[AW-1:0];
                                st_next    = ST_SHIFT_UP;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (cur_reg != '0)
                            begin
                                ptr_next = cur_reg - 1'b1;
                                raddr    = cur_reg[AW-1:0];
                                st_next  = ST_SHIFT_DN;
                            end
                        end
                        OP_LOAD:
                        begin
                            if (len_reg < FULL_LEN)
                            begin
                                we       = 1'b1;
                                waddr    = len_reg[AW-1:0];
                                wdata    = q_item.data;
                                len_next = len_reg + 1'b1;
                                cur_next = len_reg + 1'b1;
                            end
                            else
                                cur_next = len_reg;
                        end
                        OP_SAVED: dirty_next = 1'b0;
                        OP_READ:
                        begin
                            if (idx_ext < len_reg)
                            begin
                                raddr   = idx_ext[AW-1:0];
                                st_next = ST_READ_WAIT;
                            end
                        end
                        OP_CLEAR:
                        begin
                            len_next   = '0;
                            cur_next   = '0;
                            dirty_next = 1'b0;
                        end
                        OP_LEFT:
                            if (cur_reg != '0) cur_next = cur_reg - 1'b1;
                        OP_RIGHT:
                            if (cur_reg < len_reg) cur_next = cur_reg + 1'b1;
                        OP_UP, OP_DOWN:
                        begin
                            // find start of the cursor line
                            ptr_next = cur_reg;
                            raddr    = cur_reg[AW-1:0] - 1'b1;
                            st_next  = ST_SCAN_BACK;
                        end
                        default: st_next = ST_DONE;
                    endcase
                end
            end
            ST_SHIFT_UP:
            begin
                // rdata holds old byte at ptr; write carried byte there
                we        = 1'b1;
                waddr     = ptr_reg[AW-1:0];
                wdata     = hold_reg;
                hold_next = rdata_reg;
                raddr     = ptr_reg[AW-1:0] + 1'b1;
                if (ptr_reg == len_reg)
                begin
                    len_next   = len_reg + 1'b1;
                    cur_next   = cur_reg + 1'b1;
                    dirty_next = 1'b1;
                    st_next    = ST_DONE;
                end
                else
                    ptr_next = ptr_reg + 1'b1;
            end
            ST_SHIFT_DN:
            begin
                // rdata holds byte at ptr+1
                if (ptr_reg + 1'b1 >= len_reg)
                begin
                    len_next   = len_reg - 1'b1;
                    cur_next   = cur_reg - 1'b1;
                    dirty_next = 1'b1;
                    st_next    = ST_DONE;
                end
                else
                begin
                    we       = 1'b1;
                    waddr    = ptr_reg[AW-1:0];
                    wdata    = rdata_reg;
                    ptr_next = ptr_reg + 1'b1;
                    raddr    = ptr_reg[AW-1:0] + 2'd2;
                end
            end
            ST_READ_WAIT:
            begin
                rd_next = rdata_reg;
                st_next = ST_DONE;
            end
            ST_SCAN_BACK:
            begin
                // rdata is byte at ptr-1
                if (ptr_reg == '0 || rdata_reg == K_LF)
                begin
                    col_next = cur_reg - ptr_reg;
                    ls_next  = ptr_reg;
                    if (it_reg.op == OP_UP)
                    begin
                        if (ptr_reg == '0)
                            st_next = ST_DONE;
                        else
                        begin
                            ptr_next = ptr_reg - 1'b1;
                            raddr    = ptr_reg[AW-1:0] - 2'd2;
                            st_next  = ST_SCAN_BACK2;
                        end
                    end
                    else
                    begin
                        ptr_next = cur_reg;
                        raddr    = cur_reg[AW-1:0];
                        st_next  = ST_SCAN_FWD;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg - 1'b1;
                    raddr    = ptr_reg[AW-1:0] - 2'd2;
                end
            end
            ST_SCAN_BACK2:
            begin
                // find start of previous line; ls_reg-1 is its end
                if (ptr_reg == '0 || rdata_reg == K_LF)
                begin
                    cur_next = ptr_reg + min_w(col_reg, ls_reg - 1'b1 - ptr_reg);
                    st_next  = ST_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg - 1'b1;
                    raddr    = ptr_reg[AW-1:0] - 2'd2;
                end
            end
            ST_SCAN_FWD:
            begin
                if (ptr_reg >= len_reg)
                    st_next = ST_DONE;
                else if (rdata_reg == K_LF)
                begin
                    ls_next  = ptr_reg + 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                    raddr    = ptr_reg[AW-1:0] + 1'b1;
                    st_next  = ST_SCAN_FWD2;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                    raddr    = ptr_reg[AW-1:0] + 1'b1;
                end
            end
            ST_SCAN_FWD2:
            begin
                if (ptr_reg >= len_reg || rdata_reg == K_LF)
                begin
                    cur_next = ls_reg + min_w(col_reg, ptr_reg - ls_reg);
                    st_next  = ST_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                    raddr    = ptr_reg[AW-1:0] + 1'b1;
                end
            end
            ST_DONE: st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            len_reg   <= '0;
            cur_reg   <= '0;
            dirty_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            len_reg   <= len_next;
            cur_reg   <= cur_next;
            dirty_reg <= dirty_next;
            done_reg  <= (st_reg == ST_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        col_reg   <= col_next;
        ls_reg    <= ls_next;
        rd_reg    <= rd_next;
        hold_reg  <= hold_next;
        if (q_pop)
        begin
            it_reg  <= q_item;
            cmd_reg <= q_item.cmd;
        end
    end

    // result outputs
    always_comb
    begin
        done        = done_reg;
        cursor_pos  = 12'(cur_reg);
        text_length = 12'(len_reg);
        modified    = dirty_reg;
        command     = cmd_reg;
        read_data   = rd_reg;
    end

    `ASSERT_IMPL(a_cur_le_len, clk, rst_n, 1'b1, cur_reg <= len_reg)
    `ASSERT_IMPL(a_len_cap, clk, rst_n, 1'b1, len_reg <= FULL_LEN)
    `ASSERT_NEXT(a_done_pulse, clk, rst_n, st_reg == ST_DONE, done_reg && st_reg == ST_IDLE)
endmodule

// ----- hdl/keystroke_text_buffer_editor.sv -----
// keystroke text buffer editor
// requests: start with req_type, key_byte, read_index, taken when busy is low.
// each request produces one result: done pulses for one cycle with cursor_pos,
// text_length, modified, command and read_data; the receiver cannot stall.
// a decoder classifies key bytes (escape and cr/lf tracking) and hands an
// operation to the executor through a two-entry queue.
// an accepted request is written into the queue; the executor pops it in
// idle, runs its work states (a read adds a wait state), passes ST_DONE and
// registers done; the next start can be taken in the cycle after done.
// insert and delete shift the tail through the text memory one byte per cycle.
// arrow up scans back one byte a cycle over the cursor line and the previous
// line; arrow down scans back over the cursor line, then forward past its end.
// busy stays high from the accepting edge until done has been taken.
// reset clears cursor, length, modified and the key state; the text memory
// is not cleared, but a read past the length returns 0.
module keystroke_text_buffer_editor #(
    parameter int BUF_DEPTH = kted_pkg::DEF_BUF_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [7:0]  key_byte,
    input  logic [11:0] read_index,
    output logic        done,
    output logic [11:0] cursor_pos,
    output logic [11:0] text_length,
    output logic        modified,
    output logic [1:0]  command,
    output logic [7:0]  read_data
);
    import kted_pkg::*;

    cmd_item_t dec_item, q_item;
    logic      accept, q_empty, q_full, q_pop, ex_idle;
    logic      busy_reg;

    assign accept = start && !busy;
    assign busy   = busy_reg;

    // one request in flight at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (accept)
            busy_reg <= 1'b1;
        else if (done)
            busy_reg <= 1'b0;
    end

    kted_decode u_dec (
        .clk(clk), .rst_n(rst_n), .in_valid(accept), .req_type(req_type),
        .key_byte(key_byte), .read_index(read_index), .item(dec_item)
    );

    kted_fifo u_q (
        .clk(clk), .rst_n(rst_n), .wr_en(accept && !q_full), .wr_item(dec_item),
        .rd_en(q_pop), .rd_item(q_item), .empty(q_empty), .full(q_full)
    );

    kted_exec #(.BUF_DEPTH(BUF_DEPTH)) u_ex (
        .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_item(q_item), .q_pop(q_pop),
        .idle(ex_idle), .done(done), .cursor_pos(cursor_pos), .text_length(text_length),
        .modified(modified), .command(command), .read_data(read_data)
    );

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, accept, ex_idle)
    `ASSERT_IMPL(a_done_busy, clk, rst_n, done, busy_reg)
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy_reg)
endmodule
